/* src/pfj_pkg.sv */
// Shared types, constants and the saturation helper for the polynomial flux jet.
// No dependencies; every other file refers to it by scoped names.
package pfj_pkg;

  // Fixed sizes of the register file and data path
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 5;
  localparam int COUNT_W       = 3;
  localparam int ORDER_W       = 3;
  localparam int NUM_COEF_REGS = 6;
  localparam int MAX_COEFS_DEF = 6;
  localparam int VPROD_W       = 44;
  localparam int LANES         = 3;

  // Register indexes on the config port
  localparam logic [2:0] REG_COEF_COUNT = 3'd0;
  localparam logic [2:0] REG_COEF_0     = 3'd1;

  // Scale applied to v
  localparam logic signed [VPROD_W-1:0] SCALE_V = 44'sd1000;

  // Lane numbers
  localparam int LANE_F  = 0;
  localparam int LANE_D1 = 1;
  localparam int LANE_D2 = 2;

  // Sideband that travels down the pipeline with each beat
  typedef struct packed {
    logic                       valid;
    logic signed [ORDER_W-1:0]  order;
    logic signed [DATA_W-1:0]   u;
    logic signed [VPROD_W-1:0]  vprod;
    logic [LANES-1:0]           ov;
  } pfj_tag_t;

  // Saturation flags of the derivative coefficients
  typedef struct packed {
    logic ov_d1;
    logic ov_d2;
  } pfj_cov_t;

  typedef struct packed {
    logic              ov;
    logic [DATA_W-1:0] val;
  } pfj_sat_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic pfj_sat_t sat32(input logic signed [63:0] x);
    pfj_sat_t r;
    if (x > 64'sd2147483647) begin
      r.ov  = 1'b1;
      r.val = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r.ov  = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.ov  = 1'b0;
      r.val = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/pfj_coef.sv */
// Config register file (APB-style) and derivative coefficient preparation.
// Depends on pfj_pkg.
module pfj_coef #(
  parameter int MAX_COEFS = pfj_pkg::MAX_COEFS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              psel,
  input  logic                                              penable,
  input  logic                                              pwrite,
  input  logic [pfj_pkg::ADDR_W-1:0]                        paddr,
  input  logic [pfj_pkg::DATA_W-1:0]                        pwdata,
  output logic [pfj_pkg::DATA_W-1:0]                        prdata,
  output logic                                              pready,
  output logic [MAX_COEFS-1:0][pfj_pkg::LANES-1:0][pfj_pkg::DATA_W-1:0] coefs,
  output pfj_pkg::pfj_cov_t                                 cov
);

  localparam int NREG = (MAX_COEFS < pfj_pkg::NUM_COEF_REGS) ? MAX_COEFS
                                                             : pfj_pkg::NUM_COEF_REGS;
  localparam int CW   = $clog2(MAX_COEFS + 1);

  logic [pfj_pkg::COUNT_W-1:0] coef_count;
  logic [pfj_pkg::DATA_W-1:0]  coef_reg [NREG];
  logic [2:0]                  idx;
  logic                        wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_count <= pfj_pkg::COUNT_W'(1);
      for (int k = 0; k < NREG; k++) coef_reg[k] <= '0;
    end else if (wr) begin
      if (idx == pfj_pkg::REG_COEF_COUNT) coef_count <= pwdata[pfj_pkg::COUNT_W-1:0];
      for (int k = 0; k < NREG; k++) begin
        if (idx == 3'(int'(pfj_pkg::REG_COEF_0) + k)) coef_reg[k] <= pwdata;
      end
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    if (idx == pfj_pkg::REG_COEF_COUNT) prdata = pfj_pkg::DATA_W'(coef_count);
    for (int k = 0; k < NREG; k++) begin
      if (idx == 3'(int'(pfj_pkg::REG_COEF_0) + k)) prdata = coef_reg[k];
    end
  end

  // Coefficients in use, count clamped to the array size
  logic [CW-1:0]              n_eff;
  logic [pfj_pkg::DATA_W-1:0] c [MAX_COEFS];

  always_comb begin
    if (int'(coef_count) > MAX_COEFS) n_eff = CW'(MAX_COEFS);
    else                              n_eff = CW'(coef_count);
    for (int k = 0; k < MAX_COEFS; k++) begin
      c[k] = (k < NREG && k < int'(n_eff)) ? coef_reg[k < NREG ? k : 0] : '0;
    end
  end

  // Scaled derivative coefficients, shifted down so all lanes run the same Horner length
  logic [MAX_COEFS-1:0][pfj_pkg::LANES-1:0][pfj_pkg::DATA_W-1:0] coefs_next;
  pfj_pkg::pfj_cov_t cov_next;

  always_comb begin
    pfj_pkg::pfj_sat_t  s1, s2;
    logic signed [63:0] p1, p2;
    cov_next = '0;
    for (int j = 0; j < MAX_COEFS; j++) begin
      coefs_next[j][pfj_pkg::LANE_F]  = c[j];
      coefs_next[j][pfj_pkg::LANE_D1] = '0;
      coefs_next[j][pfj_pkg::LANE_D2] = '0;
      if (j + 1 < MAX_COEFS) begin
        p1 = 64'($signed(c[(j + 1) % MAX_COEFS])) * 64'(j + 1);
        s1 = pfj_pkg::sat32(p1);
        coefs_next[j][pfj_pkg::LANE_D1] = s1.val;
        if (j + 1 < int'(n_eff)) cov_next.ov_d1 = cov_next.ov_d1 | s1.ov;
      end
      if (j + 2 < MAX_COEFS) begin
        p2 = 64'($signed(c[(j + 2) % MAX_COEFS])) * 64'((j + 2) * (j + 1));
        s2 = pfj_pkg::sat32(p2);
        coefs_next[j][pfj_pkg::LANE_D2] = s2.val;
        if (j + 2 < int'(n_eff)) cov_next.ov_d2 = cov_next.ov_d2 | s2.ov;
      end
    end
  end

  always_ff @(posedge clk) begin
    coefs <= coefs_next;
    cov   <= cov_next;
  end

endmodule

/* src/pfj_hstep.sv */
// One Horner step for the three lanes: multiply stage, then round, add and saturate.
// Depends on pfj_pkg.
module pfj_hstep (
  input  logic                                              clk,
  input  logic                                              rst,
  input  pfj_pkg::pfj_tag_t                                 tag_in,
  input  logic [pfj_pkg::LANES-1:0][pfj_pkg::DATA_W-1:0]    acc_in,
  input  logic [pfj_pkg::LANES-1:0][pfj_pkg::DATA_W-1:0]    coef,
  output pfj_pkg::pfj_tag_t                                 tag_out,
  output logic [pfj_pkg::LANES-1:0][pfj_pkg::DATA_W-1:0]    acc_out
);

  pfj_pkg::pfj_tag_t  tag_a;
  logic signed [63:0] prod_a [pfj_pkg::LANES];

  // Stage A: exact product acc * u
  always_ff @(posedge clk) begin
    logic signed [31:0] a, b;
    b = tag_in.u;
    for (int l = 0; l < pfj_pkg::LANES; l++) begin
      a = acc_in[l];
      prod_a[l] <= 64'(a) * 64'(b);
    end
    if (rst) tag_a <= '0;
    else     tag_a <= tag_in;
  end

  // Stage B: round half up to Q16.16, add next coefficient, saturate
  pfj_pkg::pfj_tag_t                                tag_b_next;
  logic [pfj_pkg::LANES-1:0][pfj_pkg::DATA_W-1:0]   acc_b_next;

  always_comb begin
    logic signed [63:0] rsum;
    logic signed [47:0] rsh;
    logic signed [31:0] cf;
    pfj_pkg::pfj_sat_t  s;
    tag_b_next = tag_a;
    for (int l = 0; l < pfj_pkg::LANES; l++) begin
      rsum = prod_a[l] + 64'sd32768;
      rsh  = rsum[63:16];
      cf   = coef[l];
      s    = pfj_pkg::sat32(64'(rsh) + 64'(cf));
      acc_b_next[l]    = s.val;
      tag_b_next.ov[l] = tag_a.ov[l] | s.ov;
    end
  end

  always_ff @(posedge clk) begin
    acc_out <= acc_b_next;
    if (rst) tag_out <= '0;
    else     tag_out <= tag_b_next;
  end

endmodule

/* src/polynomial_flux_jet_top.sv */
// Top level of the polynomial flux jet: input stage, Horner pipeline, output stage.
// Depends on pfj_pkg, pfj_coef and pfj_hstep.
//
// One state point (u, v, order) is taken in every clock cycle (start high, busy low;
// busy is high only during reset). Each point gives exactly one result, shown for one
// cycle with done high; the receiver cannot hold results off, so there is no back
// pressure anywhere. The pipeline is the Horner chain: MAX_COEFS-1 steps, each a
// 32x32 multiply stage followed by a round/add/saturate stage, with f, df/du and
// d2f/du2 evaluated in parallel lanes, plus one input and one output register.
// Coefficients are to be written through the APB port only while no point is in flight;
// the block does not enforce this. No clearing pass is needed after reset.
module polynomial_flux_jet_top #(
  parameter int MAX_COEFS = pfj_pkg::MAX_COEFS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [pfj_pkg::DATA_W-1:0]   u_value,
  input  logic signed [pfj_pkg::DATA_W-1:0]   v_value,
  input  logic signed [pfj_pkg::ORDER_W-1:0]  order,
  output logic                                done,
  output logic signed [pfj_pkg::DATA_W-1:0]   flux_value,
  output logic signed [pfj_pkg::DATA_W-1:0]   scaled_v,
  output logic signed [pfj_pkg::DATA_W-1:0]   first_derivative,
  output logic signed [pfj_pkg::DATA_W-1:0]   second_derivative,
  output logic                                overflow,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pfj_pkg::ADDR_W-1:0]          paddr,
  input  logic [pfj_pkg::DATA_W-1:0]          pwdata,
  output logic [pfj_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  localparam int STEPS = MAX_COEFS - 1;

  logic [MAX_COEFS-1:0][pfj_pkg::LANES-1:0][pfj_pkg::DATA_W-1:0] coefs;
  pfj_pkg::pfj_cov_t cov;

  pfj_coef #(.MAX_COEFS(MAX_COEFS)) u_coef (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coefs  (coefs),
    .cov    (cov)
  );

  assign busy = rst;

  // Input stage: capture the beat and form the exact 1000*v product
  pfj_pkg::pfj_tag_t                                 tag [STEPS+1];
  logic [pfj_pkg::LANES-1:0][pfj_pkg::DATA_W-1:0]    acc [STEPS+1];

  always_ff @(posedge clk) begin
    tag[0].u     <= u_value;
    tag[0].order <= order;
    tag[0].vprod <= pfj_pkg::VPROD_W'(v_value) * pfj_pkg::SCALE_V;
    tag[0].ov    <= '0;
    if (rst) tag[0].valid <= 1'b0;
    else     tag[0].valid <= start && !busy;
  end

  // Horner starts from the top coefficient of every lane
  assign acc[0] = coefs[MAX_COEFS-1];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    pfj_hstep u_step (
      .clk    (clk),
      .rst    (rst),
      .tag_in (tag[s]),
      .acc_in (acc[s]),
      .coef   (coefs[MAX_COEFS-2-s]),
      .tag_out(tag[s+1]),
      .acc_out(acc[s+1])
    );
  end

  // Output stage: mask by order and merge overflow flags
  pfj_pkg::pfj_tag_t tl;
  pfj_pkg::pfj_sat_t sv_sat;
  logic              neg, ge1, ge2;

  always_comb begin
    tl     = tag[STEPS];
    sv_sat = pfj_pkg::sat32(64'(tl.vprod));
    neg    = tl.order[2];
    ge1    = !neg && (tl.order[1:0] != 2'b00);
    ge2    = !neg && tl.order[1];
  end

  always_ff @(posedge clk) begin
    flux_value        <= neg ? '0 : $signed(acc[STEPS][pfj_pkg::LANE_F]);
    scaled_v          <= neg ? '0 : $signed(sv_sat.val);
    first_derivative  <= ge1 ? $signed(acc[STEPS][pfj_pkg::LANE_D1]) : '0;
    second_derivative <= ge2 ? $signed(acc[STEPS][pfj_pkg::LANE_D2]) : '0;
    overflow <= !neg && (tl.ov[pfj_pkg::LANE_F] || sv_sat.ov
                || (ge1 && (tl.ov[pfj_pkg::LANE_D1] || cov.ov_d1))
                || (ge2 && (tl.ov[pfj_pkg::LANE_D2] || cov.ov_d2)));
    if (rst) done <= 1'b0;
    else     done <= tl.valid;
  end

endmodule

/* tb/sv/tb_polynomial_flux_jet_top.sv */
// Self-checking bench for polynomial_flux_jet_top: a predictor of f, df/du, d2f/du2 and 1000*v
// in Q16.16, a directed table, then random points under many coefficient sets.
// Depends on pfj_pkg and the RTL under src.
module tb_polynomial_flux_jet_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COEFS    = pfj_pkg::MAX_COEFS_DEF;
  localparam int NUM_REGS     = pfj_pkg::NUM_COEF_REGS + 1;
  localparam int REG_PAST_END = NUM_REGS;
  localparam int AW           = pfj_pkg::ADDR_W;
  localparam int LATENCY      = 2 * MAX_COEFS;
  localparam int PHASES       = 14;
  localparam int PHASE_POINTS = 120;
  localparam int MAX_REPORTS  = 40;

  // Order codes (3-bit signed)
  localparam logic [2:0] ORD_MOST_NEG = 3'b100;
  localparam logic [2:0] ORD_NONE     = 3'b111;
  localparam logic [2:0] ORD_NEG2     = 3'b110;
  localparam logic [2:0] ORD_NEG3     = 3'b101;
  localparam logic [2:0] ORD_VALUE    = 3'd0;
  localparam logic [2:0] ORD_FIRST    = 3'd1;
  localparam logic [2:0] ORD_SECOND   = 3'd2;
  localparam logic [2:0] ORD_THREE    = 3'd3;

  // Q16.16 landmarks
  localparam logic [31:0] Q_POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_NEG_MAX = 32'h8000_0000;
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_HALF    = 32'h0000_8000;
  localparam longint      SAT_HI    = 64'sd2147483647;
  localparam longint      SAT_LO    = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] flux;
    logic [31:0] sv;
    logic [31:0] d1;
    logic [31:0] d2;
    logic        ov;
  } jet_t;

  typedef struct packed {
    logic [31:0] u;
    logic [31:0] v;
    logic [2:0]  ord;
    logic        pinned;
    jet_t        want;
  } point_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [31:0]     u_value = '0;
  logic signed [31:0]     v_value = '0;
  logic signed [2:0]      order = '0;
  logic                   done;
  logic signed [31:0]     flux_value;
  logic signed [31:0]     scaled_v;
  logic signed [31:0]     first_derivative;
  logic signed [31:0]     second_derivative;
  logic                   overflow;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [AW-1:0]          paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // Typed expectation that rides along with a directed beat
  logic                   pin_valid = 1'b0;
  jet_t                   pin_jet = '0;

  // Shadow of the coefficient registers
  logic [2:0]             cfg_count = 3'd1;
  longint                 cfg_coef [MAX_COEFS];
  bit                     sat_hit;

  jet_t                   expected_jets [$];
  point_row_t             dir_rows [$];
  int                     unity_start;
  int                     points_sent = 0;
  int                     results_seen = 0;
  int                     mismatches = 0;

  polynomial_flux_jet_top dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .u_value           (u_value),
    .v_value           (v_value),
    .order             (order),
    .done              (done),
    .flux_value        (flux_value),
    .scaled_v          (scaled_v),
    .first_derivative  (first_derivative),
    .second_derivative (second_derivative),
    .overflow          (overflow),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp32(input longint x);
    if (x > SAT_HI) begin
      sat_hit = 1'b1;
      return SAT_HI;
    end
    if (x < SAT_LO) begin
      sat_hit = 1'b1;
      return SAT_LO;
    end
    return x;
  endfunction

  // Coefficient k of lane 0 (f), 1 (df/du) or 2 (d2f/du2), clamped to 32 bits
  function automatic longint lane_coef(input int lane, input int k);
    longint m;
    m = (lane == 0) ? 1 : (lane == 1) ? k : k * (k - 1);
    return clamp32(cfg_coef[k] * m);
  endfunction

  // Horner over coefficients lane..n-1, round half up at each step
  function automatic longint horner_lane(input int lane, input int n, input longint u);
    longint acc;
    int     k;
    if (n - 1 < lane) return 0;
    acc = lane_coef(lane, n - 1);
    for (k = n - 2; k >= lane; k--)
      acc = clamp32(((acc * u + 32768) >>> 16) + lane_coef(lane, k));
    return acc;
  endfunction

  function automatic jet_t predict_jet(input logic [31:0] u, v, input logic signed [2:0] ord);
    jet_t   r;
    int     n;
    longint uu;
    longint x;
    r       = '0;
    sat_hit = 1'b0;
    n       = (cfg_count > MAX_COEFS) ? MAX_COEFS : int'(cfg_count);
    uu      = longint'($signed(u));
    if (ord >= 0) begin
      x      = horner_lane(0, n, uu);
      r.flux = x[31:0];
      x      = clamp32(longint'($signed(v)) * 1000);
      r.sv   = x[31:0];
      if (ord >= 1) begin
        x    = horner_lane(1, n, uu);
        r.d1 = x[31:0];
      end
      if (ord >= 2) begin
        x    = horner_lane(2, n, uu);
        r.d2 = x[31:0];
      end
    end
    r.ov = sat_hit;
    return r;
  endfunction

  function automatic void shadow_write(input int idx, input logic [31:0] val);
    if (idx == int'(pfj_pkg::REG_COEF_COUNT))
      cfg_count = val[2:0];
    else if (idx < NUM_REGS)
      cfg_coef[idx - int'(pfj_pkg::REG_COEF_0)] = longint'($signed(val));
  endfunction

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string what, input logic [31:0] want, got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Record accepted beats, compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    jet_t want;
    if (!rst && start && !busy) begin
      if (pin_valid)
        expected_jets.push_back(pin_jet);
      else
        expected_jets.push_back(predict_jet(u_value, v_value, order));
      points_sent++;
    end
    if (!rst && done) begin
      if (expected_jets.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: result beat with no pending point, got f=%h", $time, flux_value);
      end else begin
        want = expected_jets.pop_front();
        results_seen++;
        check_field("flux_value", want.flux, flux_value);
        check_field("scaled_v", want.sv, scaled_v);
        check_field("first_derivative", want.d1, first_derivative);
        check_field("second_derivative", want.d2, second_derivative);
        check_field("overflow", {31'b0, want.ov}, {31'b0, overflow});
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_point(input logic [31:0] u, v, input logic [2:0] ord,
                            input logic pinned, input jet_t pj, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start     <= 1'b1;
    u_value   <= u;
    v_value   <= v;
    order     <= ord;
    pin_valid <= pinned;
    pin_jet   <= pj;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and hold off until the pipeline is empty
  task automatic wait_drained();
    @(negedge clk);
    start     <= 1'b0;
    pin_valid <= 1'b0;
    while (expected_jets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [31:0] val);
    int byte_addr;
    byte_addr = idx * 4;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= byte_addr[AW-1:0];
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_write(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [31:0] small_q();
    int s;
    s = $urandom_range(0, 262144) - 131072;
    return s;
  endfunction

  // Q16.16 value: extremes, small, near +-1.0, or any 32-bit pattern
  function automatic logic [31:0] pick_q();
    int s;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_POS_MAX;
          1: return Q_NEG_MAX;
          2: return 32'd0;
          3: return 32'hffff_ffff;
          default: return Q_ONE;
        endcase
      end
      1, 2: return small_q();
      3: begin
        s = $urandom_range(0, 4096);
        return ($urandom_range(0, 1) != 0) ? Q_ONE + s : -(Q_ONE + s);
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic jet_t mk_jet(input logic [31:0] f, sv, d1, d2, input logic ov);
    jet_t r;
    r.flux = f;
    r.sv   = sv;
    r.d1   = d1;
    r.d2   = d2;
    r.ov   = ov;
    return r;
  endfunction

  function automatic point_row_t mk_row(input logic [31:0] u, v, input logic [2:0] ord,
                                        input logic pinned, input jet_t want);
    point_row_t r;
    r.u      = u;
    r.v      = v;
    r.ord    = ord;
    r.pinned = pinned;
    r.want   = want;
    return r;
  endfunction

  // Directed table: reset coefficients first (f is zero), then all coefficients 1.0, count 6
  task automatic build_rows();
    jet_t zero;
    zero = '0;
    dir_rows.push_back(mk_row(0, 0, ORD_VALUE, 1, zero));
    dir_rows.push_back(mk_row(Q_POS_MAX, Q_POS_MAX, ORD_SECOND, 1,
                              mk_jet(0, Q_POS_MAX, 0, 0, 1)));
    dir_rows.push_back(mk_row(Q_NEG_MAX, Q_NEG_MAX, ORD_FIRST, 1,
                              mk_jet(0, Q_NEG_MAX, 0, 0, 1)));
    dir_rows.push_back(mk_row(Q_POS_MAX, Q_POS_MAX, ORD_NONE, 1, zero));
    dir_rows.push_back(mk_row(Q_NEG_MAX, Q_NEG_MAX, ORD_MOST_NEG, 1, zero));
    dir_rows.push_back(mk_row(0, 1, ORD_NEG2, 1, zero));
    dir_rows.push_back(mk_row(0, 1, ORD_NEG3, 1, zero));
    // order three behaves as order two
    dir_rows.push_back(mk_row(1, 1, ORD_THREE, 1, mk_jet(0, 1000, 0, 0, 0)));
    dir_rows.push_back(mk_row(32'hffff_ffff, 32'hffff_ffff, ORD_VALUE, 1,
                              mk_jet(0, -1000, 0, 0, 0)));
    // 1000*v right at the saturation boundary, both signs
    dir_rows.push_back(mk_row(0, 2147483, ORD_SECOND, 1, mk_jet(0, 2147483000, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, 2147484, ORD_FIRST, 1, mk_jet(0, Q_POS_MAX, 0, 0, 1)));
    dir_rows.push_back(mk_row(0, -2147483, ORD_VALUE, 1, mk_jet(0, -2147483000, 0, 0, 0)));
    dir_rows.push_back(mk_row(0, -2147484, ORD_SECOND, 1, mk_jet(0, Q_NEG_MAX, 0, 0, 1)));
    unity_start = dir_rows.size();
    // f = sum c_k u^k with every c_k = 1.0
    dir_rows.push_back(mk_row(Q_ONE, 0, ORD_SECOND, 1,
                              mk_jet(32'h0006_0000, 0, 32'h000f_0000, 32'h0028_0000, 0)));
    dir_rows.push_back(mk_row(0, 0, ORD_SECOND, 1,
                              mk_jet(Q_ONE, 0, Q_ONE, 32'h0002_0000, 0)));
    dir_rows.push_back(mk_row(-Q_ONE, Q_ONE, ORD_SECOND, 0, zero));
    dir_rows.push_back(mk_row(32'h0002_0000, Q_POS_MAX, ORD_FIRST, 0, zero));
    dir_rows.push_back(mk_row(Q_POS_MAX, 0, ORD_SECOND, 0, zero));
    dir_rows.push_back(mk_row(Q_NEG_MAX, 0, ORD_SECOND, 0, zero));
    dir_rows.push_back(mk_row(Q_HALF, Q_NEG_MAX, ORD_THREE, 0, zero));
    dir_rows.push_back(mk_row(32'hffff_ffff, 1, ORD_VALUE, 0, zero));
  endtask

  // Coefficient set for one random phase; every register is written
  task automatic load_phase(input int ph);
    logic [31:0] val;
    logic [2:0]  cnt;
    int          k;
    for (k = 0; k < MAX_COEFS; k++) begin
      case (ph)
        2:       val = Q_POS_MAX;
        3:       val = Q_NEG_MAX;
        4:       val = small_q();
        default: val = (ph % 2 == 0) ? small_q() : pick_q();
      endcase
      apb_write(int'(pfj_pkg::REG_COEF_0) + k, val);
    end
    case (ph)
      0:       cnt = 3'd0;
      1:       cnt = 3'd7;
      2, 3, 4: cnt = 3'd6;
      default: cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 6));
    endcase
    // a write past the register list must change nothing
    if (ph == 5) apb_write(REG_PAST_END, $urandom);
    apb_write(int'(pfj_pkg::REG_COEF_COUNT), {29'b0, cnt});
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : stimulus
    int          ph;
    int          i;
    int          k;
    int          gap;
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] w;
    jet_t        none;
    none = '0;
    for (k = 0; k < MAX_COEFS; k++) cfg_coef[k] = 0;
    build_rows();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < dir_rows.size(); i++) begin
      if (i == unity_start) begin
        wait_drained();
        for (k = 0; k < MAX_COEFS; k++) apb_write(int'(pfj_pkg::REG_COEF_0) + k, Q_ONE);
        apb_write(int'(pfj_pkg::REG_COEF_COUNT), 32'd6);
      end
      send_point(dir_rows[i].u, dir_rows[i].v, dir_rows[i].ord, dir_rows[i].pinned,
                 dir_rows[i].want, $urandom_range(0, 19));
    end
    wait_drained();

    // random phases; every fourth one streams a beat per cycle
    for (ph = 0; ph < PHASES; ph++) begin
      load_phase(ph);
      for (i = 0; i < PHASE_POINTS; i++) begin
        u   = pick_q();
        v   = pick_q();
        w   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2);
        gap = (ph % 4 == 1) ? 0 : $urandom_range(0, 19);
        send_point(u, v, w[2:0], 1'b0, none, gap);
      end
      wait_drained();
    end

    repeat (LATENCY + 4) @(posedge clk);
    $display("tb: %0d points over %0d coefficient sets (counts 0 to 7, saturating and small)",
             points_sent, PHASES + 2);
    $display("tb: %0d results compared, all eight order codes used", results_seen);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Run limit, far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
